// ===== rtl/hftp_pkg.sv =====
// Shared definitions for the heading-from-two-points block: default widths,
// the CORDIC arctangent table and the control bundle of the pipeline.
// No dependencies.
`timescale 1ns / 1ps

package hftp_pkg;

   // Default configuration
   localparam int COORD_WIDTH_DEF   = 16;
   localparam int ANGLE_WIDTH_DEF   = 16;
   localparam int CORDIC_STAGES_DEF = 16;

   // Fixed-point details of the CORDIC datapath
   localparam int GUARD_BITS     = 24;
   localparam int GROWTH_BITS    = 2;
   localparam int TURN_BITS      = 32;
   localparam int TABLE_DEPTH    = 24;
   localparam logic [TURN_BITS-1:0] HALF_TURN = 32'h8000_0000;

   // How the heading of an item is formed at the end of the pipeline
   typedef enum logic [2:0] {
      KIND_NORMAL  = 3'd0,
      KIND_DEGEN   = 3'd1,
      KIND_ZERO    = 3'd2,
      KIND_HALF    = 3'd3,
      KIND_QUARTER = 3'd4,
      KIND_THREEQ  = 3'd5
   } kind_type;

   // Control that travels with each item through the stages
   typedef struct packed {
      logic     valid;
      kind_type kind;
   } ctl_type;

   // atan(2^-i) / (2 pi) * 2^32, rounded to nearest
   function automatic logic [TURN_BITS-1:0] atan_entry(input int unsigned idx);
      logic [TURN_BITS-1:0] val;
      case (idx)
         0:       val = 32'd536870912;
         1:       val = 32'd316933406;
         2:       val = 32'd167458907;
         3:       val = 32'd85004756;
         4:       val = 32'd42667331;
         5:       val = 32'd21354465;
         6:       val = 32'd10679838;
         7:       val = 32'd5340245;
         8:       val = 32'd2670163;
         9:       val = 32'd1335087;
         10:      val = 32'd667544;
         11:      val = 32'd333772;
         12:      val = 32'd166886;
         13:      val = 32'd83443;
         14:      val = 32'd41722;
         15:      val = 32'd20861;
         16:      val = 32'd10430;
         17:      val = 32'd5215;
         18:      val = 32'd2608;
         19:      val = 32'd1304;
         20:      val = 32'd652;
         21:      val = 32'd326;
         22:      val = 32'd163;
         23:      val = 32'd81;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

// ===== rtl/hftp_req_if.sv =====
// Input channel: a pair of points, with valid/ready handshake.
// Depends on hftp_pkg for the default coordinate width.
`timescale 1ns / 1ps

interface hftp_req_if
   import hftp_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) ();

   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] from_x;
   logic signed [COORD_WIDTH-1:0] from_z;
   logic signed [COORD_WIDTH-1:0] to_x;
   logic signed [COORD_WIDTH-1:0] to_z;

   modport source (output valid, from_x, from_z, to_x, to_z, input ready);
   modport sink   (input valid, from_x, from_z, to_x, to_z, output ready);

endinterface

// ===== rtl/hftp_rsp_if.sv =====
// Result channel: heading and degenerate flag, with valid/ready handshake.
// Depends on hftp_pkg for the default angle width.
`timescale 1ns / 1ps

interface hftp_rsp_if
   import hftp_pkg::*;
#(
   parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) ();

   logic                   valid;
   logic                   ready;
   logic [ANGLE_WIDTH-1:0] heading;
   logic                   degenerate;

   modport source (output valid, heading, degenerate, input ready);
   modport sink   (input valid, heading, degenerate, output ready);

endinterface

// ===== rtl/hftp_front.sv =====
// Entry stage: coordinate differences, special-case sorting and the
// half-turn pre-rotation into the right half plane. Depends on hftp_pkg.
`timescale 1ns / 1ps

module hftp_front
   import hftp_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int XY_WIDTH    = COORD_WIDTH_DEF + 1 + GUARD_BITS + GROWTH_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          src_valid,
   input  logic signed [COORD_WIDTH-1:0] from_x,
   input  logic signed [COORD_WIDTH-1:0] from_z,
   input  logic signed [COORD_WIDTH-1:0] to_x,
   input  logic signed [COORD_WIDTH-1:0] to_z,
   output ctl_type                       dst_ctl,
   output logic signed [XY_WIDTH-1:0]    dst_x,
   output logic signed [XY_WIDTH-1:0]    dst_y,
   output logic [TURN_BITS-1:0]          dst_acc
);

   logic signed [COORD_WIDTH:0]   dx;
   logic signed [COORD_WIDTH:0]   dz;
   logic signed [XY_WIDTH-1:0]    dx_scaled;
   logic signed [XY_WIDTH-1:0]    dz_scaled;
   kind_type                      kind;
   ctl_type                       ctl_in, ctl_ff;
   logic signed [XY_WIDTH-1:0]    x_in, x_ff, y_in, y_ff;
   logic [TURN_BITS-1:0]          acc_in, acc_ff;

   // Form the exact differences and scale them by the guard bits
   always_comb begin
      dx        = (COORD_WIDTH+1)'(to_x) - (COORD_WIDTH+1)'(from_x);
      dz        = (COORD_WIDTH+1)'(to_z) - (COORD_WIDTH+1)'(from_z);
      dx_scaled = XY_WIDTH'(dx) <<< GUARD_BITS;
      dz_scaled = XY_WIDTH'(dz) <<< GUARD_BITS;
   end

   // Sort out the axis cases, which bypass the CORDIC result
   always_comb begin
      if (dx == '0 && dz == '0) begin
         kind = KIND_DEGEN;
      end else if (dx == '0) begin
         kind = dz[COORD_WIDTH] ? KIND_HALF : KIND_ZERO;
      end else if (dz == '0) begin
         kind = dx[COORD_WIDTH] ? KIND_THREEQ : KIND_QUARTER;
      end else begin
         kind = KIND_NORMAL;
      end
   end

   // Pre-rotate by a half turn when dz is negative
   always_comb begin
      ctl_in.valid = src_valid;
      ctl_in.kind  = kind;
      if (dz[COORD_WIDTH]) begin
         x_in   = -dz_scaled;
         y_in   = -dx_scaled;
         acc_in = HALF_TURN;
      end else begin
         x_in   = dz_scaled;
         y_in   = dx_scaled;
         acc_in = '0;
      end
   end

   // Hold on stall, advance otherwise
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (advance) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         acc_ff <= acc_in;
      end
   end

   assign dst_ctl = ctl_ff;
   assign dst_x   = x_ff;
   assign dst_y   = y_ff;
   assign dst_acc = acc_ff;

endmodule

// ===== rtl/hftp_cordic_stage.sv =====
// One registered CORDIC vectoring iteration: shift-add on x/y and the
// matching arctangent step on the angle accumulator. Depends on hftp_pkg.
`timescale 1ns / 1ps

module hftp_cordic_stage
   import hftp_pkg::*;
#(
   parameter int XY_WIDTH = COORD_WIDTH_DEF + 1 + GUARD_BITS + GROWTH_BITS,
   parameter int STAGE    = 0
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  ctl_type                    src_ctl,
   input  logic signed [XY_WIDTH-1:0] src_x,
   input  logic signed [XY_WIDTH-1:0] src_y,
   input  logic [TURN_BITS-1:0]       src_acc,
   output ctl_type                    dst_ctl,
   output logic signed [XY_WIDTH-1:0] dst_x,
   output logic signed [XY_WIDTH-1:0] dst_y,
   output logic [TURN_BITS-1:0]       dst_acc
);

   localparam logic [TURN_BITS-1:0] ATAN_STEP = atan_entry(STAGE);

   logic signed [XY_WIDTH-1:0] xs, ys;
   ctl_type                    ctl_ff;
   logic signed [XY_WIDTH-1:0] x_in, x_ff, y_in, y_ff;
   logic [TURN_BITS-1:0]       acc_in, acc_ff;

   // Rotate towards the x axis; y non-negative turns clockwise
   always_comb begin
      xs = src_x >>> STAGE;
      ys = src_y >>> STAGE;
      if (!src_y[XY_WIDTH-1]) begin
         x_in   = src_x + ys;
         y_in   = src_y - xs;
         acc_in = src_acc + ATAN_STEP;
      end else begin
         x_in   = src_x - ys;
         y_in   = src_y + xs;
         acc_in = src_acc - ATAN_STEP;
      end
   end

   // Hold on stall, advance otherwise
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (advance) begin
         ctl_ff <= src_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         acc_ff <= acc_in;
      end
   end

   assign dst_ctl = ctl_ff;
   assign dst_x   = x_ff;
   assign dst_y   = y_ff;
   assign dst_acc = acc_ff;

endmodule

// ===== rtl/heading_from_two_points.sv =====
// Heading of one point seen from another, by a pipelined CORDIC in vectoring mode.
// Pipeline: entry stage, one stage per CORDIC iteration (capped at TABLE_DEPTH), output register.
// Throughput: one transfer per cycle while the output register is free or its result is being taken.
// A stalled result holds the whole pipeline in place.
// Reset (synchronous) clears the valid bits only; payload registers are not reset.
// Depends on hftp_pkg, hftp_req_if, hftp_rsp_if, hftp_front, hftp_cordic_stage.
`timescale 1ns / 1ps

module heading_from_two_points
   import hftp_pkg::*;
#(
   parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
   parameter int ANGLE_WIDTH   = ANGLE_WIDTH_DEF,
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input logic      clock,
   input logic      reset,
   hftp_req_if.sink req_ch,
   hftp_rsp_if.source rsp_ch
);

   localparam int XY_WIDTH   = COORD_WIDTH + 1 + GUARD_BITS + GROWTH_BITS;
   localparam int NUM_STAGES = (CORDIC_STAGES < TABLE_DEPTH) ? CORDIC_STAGES
                                                              : TABLE_DEPTH;
   localparam logic [TURN_BITS-1:0] ROUND_BIT =
      TURN_BITS'(1) << (TURN_BITS - 1 - ANGLE_WIDTH);

   logic                       advance;
   ctl_type                    ctl_chain [0:NUM_STAGES];
   logic signed [XY_WIDTH-1:0] x_chain   [0:NUM_STAGES];
   logic signed [XY_WIDTH-1:0] y_chain   [0:NUM_STAGES];
   logic [TURN_BITS-1:0]       acc_chain [0:NUM_STAGES];
   ctl_type                    last_ctl;
   logic [TURN_BITS-1:0]       acc_rounded;
   logic [ANGLE_WIDTH-1:0]     heading_in, heading_ff;
   logic                       degen_in, degen_ff;
   logic                       out_valid_ff;

   // Move everything on whenever the output slot is free or being taken
   assign advance      = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = advance;

   hftp_front #(
      .COORD_WIDTH (COORD_WIDTH),
      .XY_WIDTH    (XY_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .src_valid (req_ch.valid),
      .from_x    (req_ch.from_x),
      .from_z    (req_ch.from_z),
      .to_x      (req_ch.to_x),
      .to_z      (req_ch.to_z),
      .dst_ctl   (ctl_chain[0]),
      .dst_x     (x_chain[0]),
      .dst_y     (y_chain[0]),
      .dst_acc   (acc_chain[0])
   );

   // One registered stage per CORDIC iteration
   for (genvar i = 0; i < NUM_STAGES; i++) begin : g_stage
      hftp_cordic_stage #(
         .XY_WIDTH (XY_WIDTH),
         .STAGE    (i)
      ) u_stage (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .src_ctl (ctl_chain[i]),
         .src_x   (x_chain[i]),
         .src_y   (y_chain[i]),
         .src_acc (acc_chain[i]),
         .dst_ctl (ctl_chain[i+1]),
         .dst_x   (x_chain[i+1]),
         .dst_y   (y_chain[i+1]),
         .dst_acc (acc_chain[i+1])
      );
   end

   // Round the accumulator to the output angle, or take the axis heading
   always_comb begin
      last_ctl    = ctl_chain[NUM_STAGES];
      acc_rounded = acc_chain[NUM_STAGES] + ROUND_BIT;
      degen_in    = 1'b0;
      case (last_ctl.kind)
         KIND_NORMAL:  heading_in = acc_rounded[TURN_BITS-1 -: ANGLE_WIDTH];
         KIND_DEGEN: begin
            heading_in = '0;
            degen_in   = 1'b1;
         end
         KIND_ZERO:    heading_in = '0;
         KIND_HALF:    heading_in = ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 1);
         KIND_QUARTER: heading_in = ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 2);
         KIND_THREEQ:  heading_in = ANGLE_WIDTH'(3) << (ANGLE_WIDTH - 2);
         default:      heading_in = '0;
      endcase
   end

   // Output register: hold until the transfer completes
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= last_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         heading_ff <= heading_in;
         degen_ff   <= degen_in;
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.heading    = heading_ff;
   assign rsp_ch.degenerate = degen_ff;

   // A coincident pair always reports heading zero
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.degenerate |-> rsp_ch.heading == '0)
      else $error("degenerate result with non-zero heading");

   // An accepted pair lands in the entry stage
   a_front_load: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && advance |=> ctl_chain[0].valid)
      else $error("accepted pair missing from entry stage");

   // A refused result keeps its place and value
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |=> rsp_ch.valid && $stable(rsp_ch.heading))
      else $error("stalled result lost or changed");

   // Nothing is offered straight after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("result offered after reset");

endmodule

// ===== sim/tb.sv =====
// Testbench for heading_from_two_points: directed corner cases, then random point pairs,
// each result checked against a typed-in value or a bit-exact CORDIC vectoring predictor, with random idling.
// Depends on hftp_pkg, hftp_req_if, hftp_rsp_if and the heading_from_two_points RTL.
`timescale 1ns / 1ps

module tb;
   import hftp_pkg::*;

   localparam int CW     = COORD_WIDTH_DEF;
   localparam int AW     = ANGLE_WIDTH_DEF;
   localparam int STAGES = CORDIC_STAGES_DEF;
   localparam int LATENCY = STAGES + 2;
   localparam int RANDOM_PAIRS = 950;
   localparam int IDLE_PERCENT = 29;
   localparam int DRAIN_LIMIT = 20000;

   localparam logic [AW-1:0] HEADING_NORTH = '0;
   localparam logic [AW-1:0] HEADING_EAST  = AW'(1) << (AW - 2);
   localparam logic [AW-1:0] HEADING_SOUTH = AW'(1) << (AW - 1);
   localparam logic [AW-1:0] HEADING_WEST  = AW'(3) << (AW - 2);

   typedef logic signed [CW-1:0] coord_type;
   typedef logic [AW-1:0]        angle_type;

   typedef struct packed {
      angle_type heading;
      logic      degenerate;
   } bearing_type;

   typedef struct {
      coord_type   from_x;
      coord_type   from_z;
      coord_type   to_x;
      coord_type   to_z;
      bit          fixed;
      bearing_type want;
   } pair_row_type;

   // atan(2^-i) as a fraction of a full turn, 2^32 units per turn
   localparam logic [31:0] ATAN_TURN [24] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

   logic clock;
   logic reset;
   int   fault_count = 0;
   int   sent_count = 0;
   bit   steady = 1'b0;
   bearing_type pending_bearings [$];

   hftp_req_if #(.COORD_WIDTH(CW)) req_ch ();
   hftp_rsp_if #(.ANGLE_WIDTH(AW)) rsp_ch ();

   heading_from_two_points #(
      .COORD_WIDTH(CW),
      .ANGLE_WIDTH(AW),
      .CORDIC_STAGES(STAGES)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source)
   );

   // Corner cases: typed-in results only where they are obvious
   pair_row_type corner_rows [24] = '{
      // coincident points
      '{0, 0, 0, 0, 1'b1, '{HEADING_NORTH, 1'b1}},
      '{-32768, -32768, -32768, -32768, 1'b1, '{HEADING_NORTH, 1'b1}},
      '{32767, 32767, 32767, 32767, 1'b1, '{HEADING_NORTH, 1'b1}},
      // on the Z axis
      '{5, -7, 5, 100, 1'b1, '{HEADING_NORTH, 1'b0}},
      '{0, 0, 0, 1, 1'b1, '{HEADING_NORTH, 1'b0}},
      '{0, 32767, 0, -32768, 1'b1, '{HEADING_SOUTH, 1'b0}},
      // on the X axis
      '{-32768, 0, 32767, 0, 1'b1, '{HEADING_EAST, 1'b0}},
      '{100, 200, 101, 200, 1'b1, '{HEADING_EAST, 1'b0}},
      '{32767, -5, -32768, -5, 1'b1, '{HEADING_WEST, 1'b0}},
      // largest diagonals
      '{-32768, -32768, 32767, 32767, 1'b0, '{HEADING_NORTH, 1'b0}},
      '{32767, 32767, -32768, -32768, 1'b0, '{HEADING_NORTH, 1'b0}},
      '{-32768, 32767, 32767, -32768, 1'b0, '{HEADING_NORTH, 1'b0}},
      '{32767, -32768, -32768, 32767, 1'b0, '{HEADING_NORTH, 1'b0}},
      // just off each axis, where rounding and wrapping matter
      '{0, 0, 1, 32767, 1'b0, '{HEADING_NORTH, 1'b0}},
      '{0, 0, -1, 32767, 1'b0, '{HEADING_NORTH, 1'b0}},
      '{0, 0, 1, -32768, 1'b0, '{HEADING_NORTH, 1'b0}},
      '{0, 0, -1, -32768, 1'b0, '{HEADING_NORTH, 1'b0}},
      '{0, 0, 32767, 1, 1'b0, '{HEADING_NORTH, 1'b0}},
      '{0, 0, 32767, -1, 1'b0, '{HEADING_NORTH, 1'b0}},
      '{0, 0, -32768, 1, 1'b0, '{HEADING_NORTH, 1'b0}},
      '{0, 0, -32768, -1, 1'b0, '{HEADING_NORTH, 1'b0}},
      // smallest diagonals
      '{0, 0, 1, 1, 1'b0, '{HEADING_NORTH, 1'b0}},
      '{0, 0, -1, -1, 1'b0, '{HEADING_NORTH, 1'b0}},
      '{0, 0, 1, -1, 1'b0, '{HEADING_NORTH, 1'b0}}
   };

   // Clock and reset
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Run limit, far beyond the slowest correct run
   initial begin
      #(200_000 * 12);
      $display("tb: errors");
      $finish;
   end

   task automatic note_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      fault_count++;
   endtask

   // Heading of the second point seen from the first, CORDIC in vectoring mode
   function automatic bearing_type bearing_of(input coord_type fx, input coord_type fz,
                                              input coord_type tx, input coord_type tz);
      longint      dx;
      longint      dz;
      longint      x;
      longint      y;
      longint      xs;
      longint      ys;
      longint      scale;
      logic [31:0] acc;
      bearing_type b;
      dx = longint'(tx) - longint'(fx);
      dz = longint'(tz) - longint'(fz);
      scale = longint'(1) << GUARD_BITS;
      b = '0;
      if (dx == 0 && dz == 0) begin
         b.degenerate = 1'b1;
      end else if (dx == 0) begin
         b.heading = (dz > 0) ? HEADING_NORTH : HEADING_SOUTH;
      end else if (dz == 0) begin
         b.heading = (dx > 0) ? HEADING_EAST : HEADING_WEST;
      end else begin
         // pre-rotate by a half turn when the target lies behind
         if (dz < 0) begin
            x = -dz * scale;
            y = -dx * scale;
            acc = 32'h8000_0000;
         end else begin
            x = dz * scale;
            y = dx * scale;
            acc = '0;
         end
         for (int i = 0; i < STAGES && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
               x = x + ys;
               y = y - xs;
               acc = acc + ATAN_TURN[i];
            end else begin
               x = x - ys;
               y = y + xs;
               acc = acc - ATAN_TURN[i];
            end
         end
         // round to nearest, then keep the top bits so a near-full turn wraps to zero
         acc = acc + (32'd1 << (31 - AW));
         b.heading = acc[31 -: AW];
      end
      return b;
   endfunction

   // Offer one pair, idling at random first, and wait for its transfer
   task automatic send_pair(input coord_type fx, input coord_type fz, input coord_type tx,
                            input coord_type tz, input bit fixed, input bearing_type want);
      while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.from_x <= fx;
      req_ch.from_z <= fz;
      req_ch.to_x   <= tx;
      req_ch.to_z   <= tz;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pending_bearings.push_back(fixed ? want : bearing_of(fx, fz, tx, tz));
      sent_count++;
      steady = (sent_count >= 400 && sent_count < 560);
   endtask

   function automatic coord_type any_coord();
      return coord_type'($urandom);
   endfunction

   function automatic coord_type edge_coord();
      case ($urandom_range(0, 5))
         0: return coord_type'(-32768);
         1: return coord_type'(-1);
         2: return coord_type'(0);
         3: return coord_type'(1);
         4: return coord_type'(32767);
         default: return any_coord();
      endcase
   endfunction

   // Stimulus: corner table, then random pairs of several shapes
   initial begin
      coord_type fx;
      coord_type fz;
      coord_type tx;
      coord_type tz;
      int        waited;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.from_x = '0;
      req_ch.from_z = '0;
      req_ch.to_x = '0;
      req_ch.to_z = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (corner_rows[r])
         send_pair(corner_rows[r].from_x, corner_rows[r].from_z, corner_rows[r].to_x,
                   corner_rows[r].to_z, corner_rows[r].fixed, corner_rows[r].want);

      for (int n = 0; n < RANDOM_PAIRS; n++) begin
         fx = any_coord();
         fz = any_coord();
         case ($urandom_range(0, 9))
            4, 5: begin
               // close together, coincident now and then
               tx = fx + coord_type'($urandom_range(0, 16)) - coord_type'(8);
               tz = fz + coord_type'($urandom_range(0, 16)) - coord_type'(8);
            end
            6: begin
               tx = fx;
               tz = any_coord();
            end
            7: begin
               tx = any_coord();
               tz = fz;
            end
            8: begin
               // nearly along the Z axis
               tx = fx + coord_type'($urandom_range(0, 6)) - coord_type'(3);
               tz = any_coord();
            end
            9: begin
               fx = edge_coord();
               fz = edge_coord();
               tx = edge_coord();
               tz = edge_coord();
            end
            default: begin
               tx = any_coord();
               tz = any_coord();
            end
         endcase
         send_pair(fx, fz, tx, tz, 1'b0, '0);
      end
      req_ch.valid <= 1'b0;

      // drain, then allow the pipeline to settle
      waited = 0;
      while (pending_bearings.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_bearings.size() != 0)
         note_mismatch($sformatf("%0d results never arrived", pending_bearings.size()));
      repeat (LATENCY + 4) @(posedge clock);

      if (fault_count == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

   // Result side: random back-pressure, none during the steady stretch
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   // Check each result transfer against the oldest pending bearing
   always @(posedge clock) begin
      bearing_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_bearings.size() == 0) begin
            note_mismatch($sformatf("unexpected result heading %0d degenerate %0b",
                                    rsp_ch.heading, rsp_ch.degenerate));
         end else begin
            want = pending_bearings.pop_front();
            if (rsp_ch.heading !== want.heading)
               note_mismatch($sformatf("heading %0d, expected %0d",
                                       rsp_ch.heading, want.heading));
            if (rsp_ch.degenerate !== want.degenerate)
               note_mismatch($sformatf("degenerate %0b, expected %0b",
                                       rsp_ch.degenerate, want.degenerate));
         end
      end
   end

endmodule

// ===== sim.f =====
rtl/hftp_pkg.sv
rtl/hftp_req_if.sv
rtl/hftp_rsp_if.sv
rtl/hftp_front.sv
rtl/hftp_cordic_stage.sv
rtl/heading_from_two_points.sv
sim/tb.sv
